[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; NO_ASSERTIONS removes them all.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/trkimg_pkg.sv]
// ---------------------------------------------------------------------------
// Track image parser package
// Shared constants, status codes and the result word layout.
// ---------------------------------------------------------------------------
`default_nettype none

package trkimg_pkg;

    // default limits
    localparam int MAX_TRACKS_DEF      = 160;
    localparam int MAX_TRACK_BYTES_DEF = 16384;

    // configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    // reported status
    typedef enum logic [2:0] {
        ST_PARSING  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BADHDR   = 3'd2,
        ST_BADLEN   = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    // one result word
    typedef struct packed {
        logic        write_en;
        logic [7:0]  write_track;
        logic [13:0] write_offset;
        logic [7:0]  write_value;
        logic        commit;
        logic [17:0] commit_bits;
        t_status     status;
        logic [7:0]  tracks_done;
    } t_result;

endpackage

`default_nettype wire

[hdl/track_image_stream_parser.sv]
// ---------------------------------------------------------------------------
// Track image stream parser
// Byte-wise disk image parser emitting tagged payload writes and commits.
// ---------------------------------------------------------------------------
// One byte in gives one result word out in the next cycle. A byte is taken
// every cycle while the output register is empty or being drained, so the
// sustained rate is one byte per clock; the only stall source is downstream
// backpressure on the single output register. tuser with the first-byte flag
// restarts parsing at header byte zero; tlast on a byte that leaves the image
// unfinished reports truncated. Users write expected_magic and
// expected_version via cfg only while the stream idles; not enforced.
`default_nettype none

`include "assert_macros.svh"

module track_image_stream_parser #(
    parameter int MAX_TRACKS      = trkimg_pkg::MAX_TRACKS_DEF,
    parameter int MAX_TRACK_BYTES = trkimg_pkg::MAX_TRACK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] first_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] write_track, [21:8] write_offset, [29:22] write_value,
    // [47:30] commit_bits, [50:48] status, [58:51] tracks_done, [63:59] zero
    output logic [63:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // [0] write_en, [1] commit
);

    trkimg_pkg::t_result core_res;
    trkimg_pkg::t_result out_res;
    logic                can_load;
    logic                accept;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    // parse logic and state
    trkimg_parse_core #(
        .MAX_TRACKS      (MAX_TRACKS),
        .MAX_TRACK_BYTES (MAX_TRACK_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_first     (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_data      (s_axis_tdata),
        .o_result    (core_res)
    );

    // result register
    trkimg_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (core_res),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_can_load (can_load),
        .o_result   (out_res)
    );

    // pack the result word
    assign m_axis_tdata = {5'b0, out_res.tracks_done, out_res.status, out_res.commit_bits,
                           out_res.write_value, out_res.write_offset, out_res.write_track};
    assign m_axis_tuser = {out_res.commit, out_res.write_en};

    // checks
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled with empty output register")
    `ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, m_axis_tvalid,
        "accepted byte produced no result word")
    `ASSERT_IMPL(a_badhdr_quiet, i_clk, i_rst_n,
        m_axis_tvalid && out_res.status == trkimg_pkg::ST_BADHDR,
        !out_res.write_en && !out_res.commit,
        "write or commit alongside bad header")
    `ASSERT_IMPL(a_empty_commit, i_clk, i_rst_n,
        m_axis_tvalid && out_res.commit && !out_res.write_en,
        out_res.commit_bits == 18'd0,
        "commit without write carries nonzero bit count")

endmodule

`default_nettype wire

[hdl/trkimg_parse_core.sv]
// ---------------------------------------------------------------------------
// Track image parser core
// Parse state registers and the per-byte next-state / result logic.
// ---------------------------------------------------------------------------
`default_nettype none

module trkimg_parse_core #(
    parameter int MAX_TRACKS      = trkimg_pkg::MAX_TRACKS_DEF,
    parameter int MAX_TRACK_BYTES = trkimg_pkg::MAX_TRACK_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic               i_accept,
    input  wire logic               i_first,
    input  wire logic               i_last,
    input  wire logic [7:0]         i_data,
    output trkimg_pkg::t_result     o_result
);

    localparam int TRK_W  = $clog2(MAX_TRACKS + 1);
    localparam int BL_W   = $clog2(MAX_TRACK_BYTES * 8 + 1);
    localparam int PL_W   = $clog2(MAX_TRACK_BYTES + 1);
    localparam logic [31:0] MAX_BITS   = 32'(MAX_TRACK_BYTES * 8);
    localparam logic [31:0] MAX_TRK_32 = 32'(MAX_TRACKS);

    typedef enum logic [2:0] {
        PH_HDR, PH_LEN, PH_PAY, PH_PAD, PH_DONE, PH_ERR
    } t_phase;

    // parse state
    t_phase              r_phase, c_phase, n_phase;
    logic [3:0]          r_pos, c_pos, n_pos;
    logic [31:0]         r_wb, c_wb, n_wb;
    logic [TRK_W-1:0]    r_total, c_total, n_total;
    logic [TRK_W-1:0]    r_ti, c_ti, n_ti;
    logic [BL_W-1:0]     r_bits, c_bits, n_bits;
    logic [PL_W-1:0]     r_plen, c_plen, n_plen;
    logic [PL_W-1:0]     r_pp, c_pp, n_pp;
    logic [1:0]          r_pad, c_pad, n_pad;
    trkimg_pkg::t_status r_err, c_err, n_err;
    logic                r_hdr_bad, c_hdr_bad, n_hdr_bad;
    logic [31:0]         r_magic, r_version;

    logic [31:0]         wb_acc;
    logic [TRK_W-1:0]    ti_inc;
    logic                trk_last;
    logic [PL_W-1:0]     pp_inc;
    logic [PL_W-1:0]     plen_calc;
    logic [BL_W-1:0]     len_bits;
    trkimg_pkg::t_result res;

    // start-of-image flag restarts from a clean header state
    always_comb begin
        if (i_first) begin
            c_phase   = PH_HDR;
            c_pos     = '0;
            c_wb      = '0;
            c_total   = '0;
            c_ti      = '0;
            c_bits    = '0;
            c_plen    = '0;
            c_pp      = '0;
            c_pad     = '0;
            c_err     = trkimg_pkg::ST_PARSING;
            c_hdr_bad = 1'b0;
        end else begin
            c_phase   = r_phase;
            c_pos     = r_pos;
            c_wb      = r_wb;
            c_total   = r_total;
            c_ti      = r_ti;
            c_bits    = r_bits;
            c_plen    = r_plen;
            c_pp      = r_pp;
            c_pad     = r_pad;
            c_err     = r_err;
            c_hdr_bad = r_hdr_bad;
        end
    end

    // byte lane merge, counters and length decode
    assign wb_acc    = c_wb | (32'(i_data) << {c_pos[1:0], 3'b000});
    assign ti_inc    = c_ti + 1'b1;
    assign trk_last  = (ti_inc >= c_total);
    assign pp_inc    = c_pp + 1'b1;
    assign len_bits  = wb_acc[BL_W-1:0];
    assign plen_calc = PL_W'(({1'b0, len_bits} + (BL_W+1)'(7)) >> 3);

    // next state and result
    always_comb begin
        n_phase   = c_phase;
        n_pos     = c_pos;
        n_wb      = c_wb;
        n_total   = c_total;
        n_ti      = c_ti;
        n_bits    = c_bits;
        n_plen    = c_plen;
        n_pp      = c_pp;
        n_pad     = c_pad;
        n_err     = c_err;
        n_hdr_bad = c_hdr_bad;
        res       = '0;

        case (c_phase)
            PH_HDR: begin
                n_wb = wb_acc;
                if (c_pos[1:0] == 2'd3) begin
                    if (c_pos == 4'd3 && wb_acc != r_magic) begin
                        n_hdr_bad = 1'b1;
                    end
                    if (c_pos == 4'd7 && wb_acc != r_version) begin
                        n_hdr_bad = 1'b1;
                    end
                    if (c_pos == 4'd11) begin
                        if (wb_acc == 32'd0 || wb_acc > MAX_TRK_32) begin
                            n_hdr_bad = 1'b1;
                        end else begin
                            n_total = wb_acc[TRK_W-1:0];
                        end
                    end
                    n_wb = '0;
                end
                if (c_pos == 4'd15) begin
                    if (n_hdr_bad) begin
                        n_phase = PH_ERR;
                        n_err   = trkimg_pkg::ST_BADHDR;
                    end else begin
                        n_ti    = '0;
                        n_pos   = '0;
                        n_phase = PH_LEN;
                    end
                end else begin
                    n_pos = c_pos + 1'b1;
                end
            end
            PH_LEN: begin
                n_wb = wb_acc;
                if (c_pos[1:0] == 2'd3) begin
                    n_wb = '0;
                    if (wb_acc > MAX_BITS) begin
                        n_phase = PH_ERR;
                        n_err   = trkimg_pkg::ST_BADLEN;
                    end else begin
                        n_bits = len_bits;
                        n_plen = plen_calc;
                        n_pp   = '0;
                        n_pad  = 2'(2'd0 - plen_calc[1:0]);
                        if (plen_calc == '0) begin
                            // empty track commits right away
                            res.commit      = 1'b1;
                            res.write_track = 8'(c_ti);
                            n_ti            = ti_inc;
                            n_pos           = '0;
                            n_phase         = trk_last ? PH_DONE : PH_LEN;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end else begin
                    n_pos = c_pos + 1'b1;
                end
            end
            PH_PAY: begin
                res.write_en     = 1'b1;
                res.write_track  = 8'(c_ti);
                res.write_offset = 14'(c_pp);
                res.write_value  = i_data;
                n_pp             = pp_inc;
                if (pp_inc >= c_plen) begin
                    res.commit      = 1'b1;
                    res.commit_bits = 18'(c_bits);
                    if (c_pad != 2'd0) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_ti    = ti_inc;
                        n_pos   = '0;
                        n_wb    = '0;
                        n_phase = trk_last ? PH_DONE : PH_LEN;
                    end
                end
            end
            PH_PAD: begin
                n_pad = c_pad - 1'b1;
                if (n_pad == 2'd0) begin
                    n_ti    = ti_inc;
                    n_pos   = '0;
                    n_wb    = '0;
                    n_phase = trk_last ? PH_DONE : PH_LEN;
                end
            end
            default: begin
            end
        endcase

        // end of buffer before the image is finished
        if (i_last && n_phase != PH_DONE && n_phase != PH_ERR) begin
            n_phase = PH_ERR;
            n_err   = trkimg_pkg::ST_TRUNC;
        end

        case (n_phase)
            PH_DONE: res.status = trkimg_pkg::ST_COMPLETE;
            PH_ERR:  res.status = n_err;
            default: res.status = trkimg_pkg::ST_PARSING;
        endcase
        res.tracks_done = 8'(n_ti);
    end

    assign o_result = res;

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_pos     <= '0;
            r_wb      <= '0;
            r_total   <= '0;
            r_ti      <= '0;
            r_bits    <= '0;
            r_plen    <= '0;
            r_pp      <= '0;
            r_pad     <= '0;
            r_err     <= trkimg_pkg::ST_PARSING;
            r_hdr_bad <= 1'b0;
            r_magic   <= '0;
            r_version <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    trkimg_pkg::CFG_MAGIC:   r_magic   <= i_cfg_wdata;
                    trkimg_pkg::CFG_VERSION: r_version <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_pos     <= n_pos;
                r_wb      <= n_wb;
                r_total   <= n_total;
                r_ti      <= n_ti;
                r_bits    <= n_bits;
                r_plen    <= n_plen;
                r_pp      <= n_pp;
                r_pad     <= n_pad;
                r_err     <= n_err;
                r_hdr_bad <= n_hdr_bad;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/trkimg_out_reg.sv]
// ---------------------------------------------------------------------------
// Track image parser output register
// Holds one result word; refills in the cycle the held word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module trkimg_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  trkimg_pkg::t_result      i_result,
    input  wire logic                i_m_ready,
    output logic                     o_m_valid,
    output logic                     o_can_load,
    output trkimg_pkg::t_result      o_result
);

    logic                r_valid;
    trkimg_pkg::t_result r_result;

    // free when empty or being drained this cycle
    assign o_can_load = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_valid = r_valid;
    assign o_result  = r_result;

endmodule

`default_nettype wire
